@@ hw/rtl/cci_pkg.sv @@
// Shared types, constants and helpers for the covariance inverter.
package cci_pkg;

   localparam int MaxDim   = 16;
   localparam int TriDepth = MaxDim * (MaxDim + 1) / 2;
   localparam int DimW     = $clog2(MaxDim);
   localparam int AddrW    = $clog2(TriDepth);
   localparam int ValW     = 48;
   localparam int FracW    = 24;

   localparam logic signed [ValW-1:0] VMax = {1'b0, {(ValW-1){1'b1}}};
   localparam logic signed [ValW-1:0] VMin = {1'b1, {(ValW-1){1'b0}}};
   localparam logic signed [ValW-1:0] FxOne = ValW'(64'sd1 << FracW);
   localparam logic [31:0] Ln2Q32 = 32'd2977044472;

   typedef logic signed [ValW-1:0] val_type;
   typedef logic [AddrW-1:0] addr_type;
   typedef logic [DimW-1:0] idx_type;

   typedef enum logic [1:0] {
      REQ_WRITE   = 2'd0,
      REQ_COMPUTE = 2'd1,
      REQ_READ    = 2'd2,
      REQ_NONE    = 2'd3
   } req_type_type;

   // datapath operations issued by the controller
   typedef enum logic [2:0] {
      OP_LOAD = 3'd0,  // acc <= operand a
      OP_ZERO = 3'd1,  // acc <= 0
      OP_MSUB = 3'd2,  // acc <= acc - a*b
      OP_DIV  = 3'd3,  // res <= acc / a
      OP_SQRT = 3'd4,  // res <= sqrt(acc)
      OP_LN   = 3'd5,  // res <= ln(a)
      OP_NOP  = 3'd6
   } op_type;

   typedef struct packed {
      logic   start;
      op_type op;
      val_type a;
      val_type b;
   } dp_cmd_type;

   typedef struct packed {
      logic    busy;
      logic    done;
      val_type acc;
      val_type res;
   } dp_sts_type;

   function automatic addr_type tri_addr(input idx_type r, input idx_type c);
      logic [AddrW+DimW:0] p;
      p = ({1'b0, r} * ({1'b0, r} + 1'b1)) >> 1;
      return addr_type'(p + c);
   endfunction

   function automatic val_type sat_add(input val_type a, input val_type b);
      logic signed [ValW:0] s;
      s = {a[ValW-1], a} + {b[ValW-1], b};
      if (s > $signed({1'b0, VMax})) return VMax;
      if (s < $signed({1'b1, VMin})) return VMin;
      return val_type'(s);
   endfunction

   function automatic val_type sat_sub(input val_type a, input val_type b);
      logic signed [ValW:0] s;
      s = {a[ValW-1], a} - {b[ValW-1], b};
      if (s > $signed({1'b0, VMax})) return VMax;
      if (s < $signed({1'b1, VMin})) return VMin;
      return val_type'(s);
   endfunction

   function automatic logic [ValW-1:0] mag(input val_type v);
      return v[ValW-1] ? ValW'(-v) : ValW'(v);
   endfunction

   function automatic val_type from_mag(input logic neg, input logic [63:0] m);
      if (neg) return (m >= 64'(1) << (ValW-1)) ? VMin : val_type'(-m);
      return (m > 64'(VMax)) ? VMax : val_type'(m);
   endfunction

endpackage

@@ hw/rtl/cci_if.sv @@
// Valid/ready channel interfaces for requests, responses and configuration.
interface cci_req_if;
   import cci_pkg::*;
   logic    valid;
   logic    ready;
   logic [1:0] req_type;
   idx_type row;
   idx_type col;
   val_type value;
   modport source (output valid, req_type, row, col, value, input ready);
   modport sink (input valid, req_type, row, col, value, output ready);
endinterface

interface cci_rsp_if;
   import cci_pkg::*;
   logic    valid;
   logic    ready;
   val_type result_value;
   logic    status;
   modport source (output valid, result_value, status, input ready);
   modport sink (input valid, result_value, status, output ready);
endinterface

interface cci_csr_if;
   logic       valid;
   logic       ready;
   logic [4:0] matrix_size;
   modport source (output valid, matrix_size, input ready);
   modport sink (input valid, matrix_size, output ready);
endinterface

@@ hw/rtl/cci_datapath.sv @@
// Shared arithmetic unit: multiply-subtract, serial divide, sqrt and ln.
module cci_datapath (
   input  logic               clock,
   input  logic               reset,
   input  cci_pkg::dp_cmd_type cmd,
   output cci_pkg::dp_sts_type sts
);
   import cci_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_MUL  = 6'b000010,
      S_DIV  = 6'b000100,
      S_SQRT = 6'b001000,
      S_LN   = 6'b010000,
      S_LNM  = 6'b100000
   } st_type;

   st_type st_ff, st_in;
   val_type acc_ff, acc_in, res_ff, res_in;
   logic done_ff, done_in;
   logic neg_ff, neg_in;
   logic [ValW-1:0] ma_ff, ma_in, mb_ff, mb_in;
   logic [1:0] ph_ff, ph_in;
   logic [63:0] pacc_ff, pacc_in;
   logic [72:0] rem_ff, rem_in;
   logic [72:0] q_ff, q_in;
   logic [6:0] cnt_ff, cnt_in;
   logic [63:0] m_ff, m_in;
   logic [5:0] t_ff, t_in;

   logic [23:0] a1, a0, b1, b0;
   logic [47:0] pp;
   logic [63:0] sq;
   logic [72:0] rsh, tt;
   logic [63:0] l2m;
   logic signed [63:0] l2;
   logic [95:0] lp;
   logic [71:0] qq;

   always_comb begin
      st_in = st_ff; acc_in = acc_ff; res_in = res_ff; done_in = 1'b0;
      neg_in = neg_ff; ma_in = ma_ff; mb_in = mb_ff; ph_in = ph_ff;
      pacc_in = pacc_ff; rem_in = rem_ff; q_in = q_ff; cnt_in = cnt_ff;
      m_in = m_ff; t_in = t_ff;
      a1 = ma_ff[47:24]; a0 = ma_ff[23:0]; b1 = mb_ff[47:24]; b0 = mb_ff[23:0];
      pp = '0; sq = '0; rsh = '0; tt = '0; l2 = '0; l2m = '0; lp = '0; qq = '0;
      case (st_ff)
         S_IDLE: begin
            if (cmd.start) begin
               case (cmd.op)
                  OP_LOAD: begin acc_in = cmd.a; done_in = 1'b1; end
                  OP_ZERO: begin acc_in = '0; done_in = 1'b1; end
                  OP_MSUB: begin
                     neg_in = cmd.a[ValW-1] ^ cmd.b[ValW-1];
                     ma_in = mag(cmd.a); mb_in = mag(cmd.b);
                     ph_in = '0; pacc_in = '0; st_in = S_MUL;
                  end
                  OP_DIV: begin
                     neg_in = acc_ff[ValW-1] ^ cmd.a[ValW-1];
                     ma_in = mag(acc_ff); mb_in = mag(cmd.a);
                     // restoring divide of ma*2^24 by mb, one bit a cycle
                     rem_in = '0; q_in = '0; cnt_in = 7'd72;
                     st_in = S_DIV;
                  end
                  OP_SQRT: begin
                     ma_in = ValW'(acc_ff); rem_in = '0; q_in = '0;
                     cnt_in = 7'd36; st_in = S_SQRT;
                  end
                  OP_LN: begin
                     ma_in = ValW'(cmd.a); t_in = '0; cnt_in = 7'd47;
                     st_in = S_LN;
                  end
                  default: done_in = 1'b1;
               endcase
            end
         end
         S_MUL: begin
            // one 24x24 partial product a cycle
            case (ph_ff)
               2'd0: begin pp = a0 * b0; pacc_in = 64'((pp + 48'h800000) >> 24); end
               2'd1: begin pp = a1 * b0; pacc_in = pacc_ff + 64'(pp); end
               2'd2: begin pp = a0 * b1; pacc_in = pacc_ff + 64'(pp); end
               default: begin
                  pp = a1 * b1;
                  if (pp >= 48'h800000)
                     acc_in = sat_sub(acc_ff, neg_ff ? VMin : VMax);
                  else
                     acc_in = sat_sub(acc_ff,
                        from_mag(neg_ff, pacc_ff + (64'(pp) << 24)));
                  done_in = 1'b1; st_in = S_IDLE;
               end
            endcase
            ph_in = ph_ff + 2'd1;
         end
         S_DIV: begin
            if (mb_ff == '0) begin
               res_in = acc_ff[ValW-1] ? VMin : VMax;
               done_in = 1'b1; st_in = S_IDLE;
            end else if (cnt_ff != 0) begin
               qq = {ma_ff, 24'd0};
               rsh = {rem_ff[71:0], qq[cnt_ff-7'd1]};
               if (rsh >= 73'(mb_ff)) begin
                  rem_in = rsh - 73'(mb_ff); q_in = {q_ff[71:0], 1'b1};
               end else begin
                  rem_in = rsh; q_in = {q_ff[71:0], 1'b0};
               end
               cnt_in = cnt_ff - 7'd1;
            end else begin
               if (q_ff >= 73'(1) << 47) res_in = neg_ff ? VMin : VMax;
               else begin
                  tt = q_ff + ((rem_ff << 1) >= 73'(mb_ff) ? 73'd1 : 73'd0);
                  res_in = from_mag(neg_ff, tt[63:0]);
               end
               done_in = 1'b1; st_in = S_IDLE;
            end
         end
         S_SQRT: begin
            if (cnt_ff != 0) begin
               qq = {ma_ff, 24'd0};
               rsh = {rem_ff[70:0], qq[2*cnt_ff-7'd1], qq[2*cnt_ff-7'd2]};
               tt = {q_ff[70:0], 2'b01};
               if (rsh >= tt) begin
                  rem_in = rsh - tt; q_in = {q_ff[71:0], 1'b1};
               end else begin
                  rem_in = rsh; q_in = {q_ff[71:0], 1'b0};
               end
               cnt_in = cnt_ff - 7'd1;
            end else begin
               tt = q_ff + (rem_ff > q_ff ? 73'd1 : 73'd0);
               res_in = (tt > 73'(VMax)) ? VMax : val_type'(tt);
               done_in = 1'b1; st_in = S_IDLE;
            end
         end
         S_LN: begin
            // top set bit search, one bit a cycle
            if (ma_ff[ValW-1] == 1'b0 && ma_ff != '0) begin
               if (ma_ff[cnt_ff[5:0]]) begin
                  t_in = cnt_ff[5:0];
                  m_in = (cnt_ff >= 7'd30) ? 64'(ma_ff >> (cnt_ff - 7'd30))
                                            : 64'(ma_ff) << (7'd30 - cnt_ff);
                  q_in = '0; cnt_in = 7'd24; st_in = S_LNM;
               end else cnt_in = cnt_ff - 7'd1;
            end else begin
               res_in = '0; done_in = 1'b1; st_in = S_IDLE;
            end
         end
         S_LNM: begin
            if (cnt_ff != 0) begin
               sq = (m_ff[31:0] * m_ff[31:0]) >> 30;
               if (sq >= 64'(1) << 31) begin
                  m_in = sq >> 1; q_in = {q_ff[71:0], 1'b1};
               end else begin
                  m_in = sq; q_in = {q_ff[71:0], 1'b0};
               end
               cnt_in = cnt_ff - 7'd1;
            end else begin
               l2 = (64'(signed'({1'b0, t_ff})) - 64'sd24) * 64'sd16777216
                    + 64'(q_ff[23:0]);
               l2m = l2[63] ? -l2 : l2;
               lp = (96'(l2m) * 96'(Ln2Q32) + (96'(1) << 31)) >> 32;
               res_in = from_mag(l2[63], lp[63:0]);
               done_in = 1'b1; st_in = S_IDLE;
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; done_ff <= 1'b0;
      end else begin
         st_ff <= st_in; done_ff <= done_in;
      end
      acc_ff <= acc_in; res_ff <= res_in; neg_ff <= neg_in; ma_ff <= ma_in;
      mb_ff <= mb_in; ph_ff <= ph_in; pacc_ff <= pacc_in; rem_ff <= rem_in;
      q_ff <= q_in; cnt_ff <= cnt_in; m_ff <= m_in; t_ff <= t_in;
   end

   assign sts.busy = (st_ff != S_IDLE);
   assign sts.done = done_ff;
   assign sts.acc = acc_ff;
   assign sts.res = res_ff;
endmodule

@@ hw/rtl/cci_controller.sv @@
// Sequencer: stores, request handling and factor/solve loop control.
module cci_controller (
   input  logic                clock,
   input  logic                reset,
   cci_req_if.sink             req,
   cci_rsp_if.source           rsp,
   cci_csr_if.sink             csr,
   output cci_pkg::dp_cmd_type cmd,
   input  cci_pkg::dp_sts_type sts
);
   import cci_pkg::*;

   typedef enum logic [12:0] {
      C_IDLE  = 13'b0000000000001,
      C_RDM   = 13'b0000000000010,
      C_FI    = 13'b0000000000100,  // factor entry start
      C_FK    = 13'b0000000001000,  // factor inner product step
      C_FE    = 13'b0000000010000,  // factor sqrt / divide result write
      C_SF    = 13'b0000000100000,  // forward row start
      C_SFK   = 13'b0000001000000,
      C_SFE   = 13'b0000010000000,
      C_SBK   = 13'b0000100000000,
      C_SBE   = 13'b0001000000000,
      C_LN    = 13'b0010000000000,
      C_WAIT  = 13'b0100000000000,
      C_OUT   = 13'b1000000000000
   } cst_type;

   // storage arrays
   val_type cov_mem [TriDepth];
   val_type fac_mem [TriDepth];
   val_type inv_mem [TriDepth];
   val_type fwd_mem [MaxDim];
   val_type bwd_mem [MaxDim];

   cst_type st_ff, st_in, ret_ff, ret_in;
   logic [4:0] size_ff, size_in;
   logic [DimW:0] n_ff, n_in, i_ff, i_in, j_ff, j_in, k_ff, k_in, c_ff, c_in;
   logic [1:0] ph_ff, ph_in;
   val_type fa_ff, fb_ff, diag_ff;
   val_type lsum_ff, lsum_in;
   val_type out_ff, out_in;
   logic stat_ff, stat_in, ov_ff, ov_in;
   logic bwd_ff, bwd_in;
   dp_cmd_type cmd_in;

   // memory addresses
   addr_type fa_addr, fb_addr, cov_addr;
   idx_type vec_addr;
   val_type inv_rd, cov_rd, vec_rd;
   logic fac_we, inv_we, fwd_we, bwd_we;
   addr_type wr_addr;
   val_type wr_data;
   idx_type vec_waddr;

   idx_type rr, cc;
   always_comb begin
      rr = (req.row < req.col) ? req.col : req.row;
      cc = (req.row < req.col) ? req.row : req.col;
   end

   function automatic idx_type ix(input logic [DimW:0] v);
      return v[DimW-1:0];
   endfunction

   always_comb begin
      st_in = st_ff; ret_in = ret_ff; size_in = size_ff; n_in = n_ff; i_in = i_ff;
      j_in = j_ff; k_in = k_ff; c_in = c_ff; ph_in = ph_ff; lsum_in = lsum_ff;
      out_in = out_ff; stat_in = stat_ff; ov_in = ov_ff; bwd_in = bwd_ff;
      cmd_in = '0; cmd_in.op = OP_NOP;
      fa_addr = '0; fb_addr = '0; cov_addr = '0; vec_addr = '0;
      fac_we = 1'b0; inv_we = 1'b0; fwd_we = 1'b0; bwd_we = 1'b0;
      wr_addr = '0; wr_data = sts.res; vec_waddr = '0;
      if (csr.valid) size_in = csr.matrix_size;
      case (st_ff)
         C_IDLE: begin
            if (req.valid) begin
               case (req_type_type'(req.req_type))
                  REQ_READ: st_in = C_RDM;
                  REQ_COMPUTE: begin
                     n_in = (size_ff == 0) ? (DimW+1)'(1)
                          : (size_ff > 5'(MaxDim)) ? (DimW+1)'(MaxDim)
                          : (DimW+1)'(size_ff);
                     i_in = '0; j_in = '0; lsum_in = '0; ph_in = '0;
                     st_in = C_FI;
                  end
                  default: ;
               endcase
            end
         end
         C_RDM: begin
            out_in = inv_rd; stat_in = 1'b0; st_in = C_OUT;
         end
         // ---- factorisation: L[i][j]
         C_FI: begin
            cov_addr = tri_addr(ix(i_ff), ix(j_ff));
            if (ph_ff == 0) ph_in = 2'd1;
            else begin
               cmd_in.start = 1'b1; cmd_in.op = OP_LOAD; cmd_in.a = cov_rd;
               k_in = '0; ph_in = '0; ret_in = C_FK; st_in = C_WAIT;
            end
         end
         C_FK: begin
            fa_addr = tri_addr(ix(i_ff), ix(k_ff));
            fb_addr = tri_addr(ix(j_ff), ix(k_ff));
            if (k_ff == j_ff) begin
               fb_addr = tri_addr(ix(j_ff), ix(j_ff));
               if (ph_ff == 0) ph_in = 2'd1;
               else begin
                  ph_in = '0;
                  if (i_ff == j_ff) begin
                     if (sts.acc[ValW-1] || sts.acc == '0) begin
                        out_in = '0; stat_in = 1'b1; st_in = C_OUT;
                     end else begin
                        cmd_in.start = 1'b1; cmd_in.op = OP_SQRT;
                        ret_in = C_FE; st_in = C_WAIT;
                     end
                  end else if (fb_ff == '0) begin
                     out_in = '0; stat_in = 1'b1; st_in = C_OUT;
                  end else begin
                     cmd_in.start = 1'b1; cmd_in.op = OP_DIV; cmd_in.a = fb_ff;
                     ret_in = C_FE; st_in = C_WAIT;
                  end
               end
            end else if (ph_ff == 0) ph_in = 2'd1;
            else begin
               cmd_in.start = 1'b1; cmd_in.op = OP_MSUB;
               cmd_in.a = fa_ff; cmd_in.b = fb_ff;
               k_in = k_ff + 1'b1; ph_in = '0; ret_in = C_FK; st_in = C_WAIT;
            end
         end
         C_FE: begin
            fac_we = 1'b1; wr_addr = tri_addr(ix(i_ff), ix(j_ff));
            if (j_ff == i_ff) begin
               j_in = '0;
               if (i_ff + 1'b1 == n_ff) begin
                  c_in = '0; i_in = '0; st_in = C_SF;
               end else begin
                  i_in = i_ff + 1'b1; st_in = C_FI;
               end
            end else begin
               j_in = j_ff + 1'b1; st_in = C_FI;
            end
         end
         // ---- forward solve of column c, row i
         C_SF: begin
            cmd_in.start = 1'b1;
            if (i_ff == c_ff) begin cmd_in.op = OP_LOAD; cmd_in.a = FxOne; end
            else cmd_in.op = OP_ZERO;
            k_in = c_ff; ph_in = '0; ret_in = C_SFK; st_in = C_WAIT;
         end
         C_SFK: begin
            fa_addr = tri_addr(ix(i_ff), ix(k_ff));
            fb_addr = tri_addr(ix(i_ff), ix(i_ff));
            vec_addr = ix(k_ff);
            if (ph_ff == 0) ph_in = 2'd1;
            else if (k_ff == i_ff) begin
               cmd_in.start = 1'b1; cmd_in.op = OP_DIV; cmd_in.a = fb_ff;
               ph_in = '0; ret_in = C_SFE; st_in = C_WAIT;
            end else begin
               cmd_in.start = 1'b1; cmd_in.op = OP_MSUB;
               cmd_in.a = fa_ff; cmd_in.b = vec_rd;
               k_in = k_ff + 1'b1; ph_in = '0; ret_in = C_SFK; st_in = C_WAIT;
            end
         end
         C_SFE: begin
            fwd_we = 1'b1; vec_waddr = ix(i_ff);
            if (i_ff + 1'b1 == n_ff) begin
               i_in = n_ff - 1'b1; ph_in = '0; bwd_in = 1'b1; st_in = C_SBK;
               k_in = n_ff;
            end else begin
               i_in = i_ff + 1'b1; st_in = C_SF;
            end
         end
         // ---- backward solve: acc = fwd[i] - sum L[k][i]*bwd[k]
         C_SBK: begin
            fa_addr = tri_addr(ix(k_ff), ix(i_ff));
            fb_addr = tri_addr(ix(i_ff), ix(i_ff));
            vec_addr = bwd_ff ? ix(i_ff) : ix(k_ff);
            if (ph_ff == 0) ph_in = 2'd1;
            else if (bwd_ff) begin
               cmd_in.start = 1'b1; cmd_in.op = OP_LOAD; cmd_in.a = vec_rd;
               bwd_in = 1'b0; k_in = i_ff + 1'b1; ph_in = '0;
               ret_in = C_SBK; st_in = C_WAIT;
            end else if (k_ff == n_ff) begin
               cmd_in.start = 1'b1; cmd_in.op = OP_DIV; cmd_in.a = fb_ff;
               ph_in = '0; ret_in = C_SBE; st_in = C_WAIT;
            end else begin
               cmd_in.start = 1'b1; cmd_in.op = OP_MSUB;
               cmd_in.a = fa_ff; cmd_in.b = vec_rd;
               k_in = k_ff + 1'b1; ph_in = '0; ret_in = C_SBK; st_in = C_WAIT;
            end
         end
         C_SBE: begin
            bwd_we = 1'b1; vec_waddr = ix(i_ff);
            if (i_ff >= c_ff) begin
               inv_we = 1'b1; wr_addr = tri_addr(ix(i_ff), ix(c_ff));
            end
            if (i_ff == 0) begin
               ph_in = '0; st_in = C_LN;
            end else begin
               i_in = i_ff - 1'b1; bwd_in = 1'b1; ph_in = '0; st_in = C_SBK;
            end
         end
         C_LN: begin
            fb_addr = tri_addr(ix(c_ff), ix(c_ff));
            if (ph_ff == 0) ph_in = 2'd1;
            else if (ph_ff == 1) begin
               cmd_in.start = 1'b1; cmd_in.op = OP_LN; cmd_in.a = fb_ff;
               ph_in = 2'd2; ret_in = C_LN; st_in = C_WAIT;
            end else begin
               lsum_in = sat_add(lsum_ff, sts.res); ph_in = '0;
               if (c_ff + 1'b1 == n_ff) begin
                  out_in = sat_add(lsum_in, lsum_in); stat_in = 1'b0;
                  st_in = C_OUT;
               end else begin
                  c_in = c_ff + 1'b1; i_in = c_ff + 1'b1; st_in = C_SF;
               end
            end
         end
         C_WAIT: begin
            if (sts.done) st_in = ret_ff;
         end
         C_OUT: begin
            // hand the result to the output register once it is free
            if (!ov_ff || rsp.ready) begin
               ov_in = 1'b1; st_in = C_IDLE;
            end
         end
         default: st_in = C_IDLE;
      endcase
      if (ov_ff && rsp.ready && st_ff != C_OUT) ov_in = 1'b0;
   end

   assign req.ready = (st_ff == C_IDLE);
   assign csr.ready = 1'b1;
   assign rsp.valid = ov_ff;

   val_type rsp_val_ff;
   logic rsp_st_ff;
   assign rsp.result_value = rsp_val_ff;
   assign rsp.status = rsp_st_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= C_IDLE; ret_ff <= C_IDLE; size_ff <= 5'd16; ov_ff <= 1'b0;
      end else begin
         st_ff <= st_in; ret_ff <= ret_in; size_ff <= size_in; ov_ff <= ov_in;
      end
      if (st_ff == C_OUT && (!ov_ff || rsp.ready)) begin
         rsp_val_ff <= out_ff; rsp_st_ff <= stat_ff;
      end
      n_ff <= n_in; i_ff <= i_in; j_ff <= j_in; k_ff <= k_in; c_ff <= c_in;
      ph_ff <= ph_in; lsum_ff <= lsum_in; out_ff <= out_in; stat_ff <= stat_in;
      bwd_ff <= bwd_in;
      cmd <= cmd_in;
      // memories
      if (req.valid && req.ready && req_type_type'(req.req_type) == REQ_WRITE)
         cov_mem[tri_addr(rr, cc)] <= req.value;
      cov_rd <= cov_mem[cov_addr];
      if (fac_we) fac_mem[wr_addr] <= wr_data;
      fa_ff <= fac_mem[fa_addr];
      diag_ff <= fac_mem[fb_addr];
      if (inv_we) inv_mem[wr_addr] <= wr_data;
      if (req.valid && req.ready) inv_rd <= inv_mem[tri_addr(rr, cc)];
      if (fwd_we) fwd_mem[vec_waddr] <= wr_data;
      if (bwd_we) bwd_mem[vec_waddr] <= wr_data;
      vec_rd <= (st_ff == C_SBK) ? (bwd_ff ? fwd_mem[vec_addr] : bwd_mem[vec_addr])
                                 : fwd_mem[vec_addr];
   end
   assign fb_ff = diag_ff;
endmodule

@@ hw/rtl/cholesky_covariance_inverse.sv @@
// Top level of the Cholesky covariance matrix inverter.
// Usage:
//  - req beats: req_type 0 writes a lower-triangle covariance entry (row,col,
//    mirrored if row<col), 1 computes the inverse, 2 reads an inverse entry.
//    Values are signed Q24 in 48 bits; arithmetic saturates.
//  - rsp beats: one per compute (log-determinant, status 1 when the matrix
//    is not positive definite) and one per read (inverse entry); none per write.
//  - csr beat: sets matrix_size (0 acts as 1, above 16 acts as 16). Write
//    only while idle.
//  - A read goes through the store read and out registers to the rsp register.
//  - A compute runs on one shared arithmetic unit for multiply-subtract,
//    divide, square root and ln. Total is cubic in matrix_size: about 5n^3/6
//    multiply steps and about 2n^2 divides.
//  - One request at a time: req_ready is high only while the sequencer
//    is idle. A finished result sits in the rsp register; a stalled
//    receiver holds it and blocks only the next result, not the next
//    request.
//  - Reset sets matrix_size to 16 and drops any pending beat; stores are
//    undefined until written.
module cholesky_covariance_inverse (
   input  logic       clock,
   input  logic       reset,
   cci_req_if.sink    req,
   cci_rsp_if.source  rsp,
   cci_csr_if.sink    csr
);
   import cci_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;

   cci_controller u_ctrl (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp),
      .csr   (csr),
      .cmd   (cmd),
      .sts   (sts)
   );

   cci_datapath u_dp (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .sts   (sts)
   );
endmodule
